@@ rtl/core/udr_pkg.sv @@
// Shared types, constants and byte-patch helper for the UDP destination rewrite block.
package udr_pkg;

   // Number of header bytes held before a frame is judged
   localparam int unsigned HOLD_LEN = 42;
   localparam int unsigned POS_W    = $clog2(HOLD_LEN + 1);

   // Header byte offsets in wire order
   localparam logic [POS_W-1:0] IDX_ETYPE_HI = POS_W'(12);
   localparam logic [POS_W-1:0] IDX_ETYPE_LO = POS_W'(13);
   localparam logic [POS_W-1:0] IDX_IP_FIRST = POS_W'(14);
   localparam logic [POS_W-1:0] IDX_PROTO    = POS_W'(23);
   localparam logic [POS_W-1:0] IDX_CHECK_HI = POS_W'(24);
   localparam logic [POS_W-1:0] IDX_CHECK_LO = POS_W'(25);
   localparam logic [POS_W-1:0] IDX_DADDR_0  = POS_W'(30);
   localparam logic [POS_W-1:0] IDX_DADDR_1  = POS_W'(31);
   localparam logic [POS_W-1:0] IDX_DADDR_2  = POS_W'(32);
   localparam logic [POS_W-1:0] IDX_DADDR_3  = POS_W'(33);
   localparam logic [POS_W-1:0] IDX_DPORT_HI = POS_W'(36);
   localparam logic [POS_W-1:0] IDX_DPORT_LO = POS_W'(37);
   localparam logic [POS_W-1:0] IDX_LAST_HDR = POS_W'(HOLD_LEN - 1);

   // Protocol constants
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;

   // Register reset values
   localparam logic [31:0] RST_MATCH_ADDR  = 32'h7F00_0002;
   localparam logic [15:0] RST_MATCH_PORT  = 16'd7072;
   localparam logic [31:0] RST_TARGET_ADDR = 32'h7F00_0001;
   localparam logic [15:0] RST_TARGET_PORT = 16'd7073;

   // Register index map
   localparam int unsigned CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MATCH_ADDR  = 2'd0,
      CSR_MATCH_PORT  = 2'd1,
      CSR_TARGET_ADDR = 2'd2,
      CSR_TARGET_PORT = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [31:0] match_address;
      logic [15:0] match_port;
      logic [31:0] target_address;
      logic [15:0] target_port;
   } cfg_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       verdict;
   } rsp_type;

   // One step of the shared header unit
   typedef struct packed {
      logic             clear;
      logic             enable;
      logic [POS_W-1:0] idx;
   } step_type;

   // Byte of a redirected header: new destination, new port or rebuilt checksum
   function automatic logic [7:0] hdr_patch(input logic [POS_W-1:0] idx,
                                            input logic [7:0] b,
                                            input logic [15:0] check,
                                            input cfg_type cfg);
      logic [7:0] r;
      r = b;
      case (idx)
         IDX_CHECK_HI: r = check[15:8];
         IDX_CHECK_LO: r = check[7:0];
         IDX_DADDR_0:  r = cfg.target_address[31:24];
         IDX_DADDR_1:  r = cfg.target_address[23:16];
         IDX_DADDR_2:  r = cfg.target_address[15:8];
         IDX_DADDR_3:  r = cfg.target_address[7:0];
         IDX_DPORT_HI: r = cfg.target_port[15:8];
         IDX_DPORT_LO: r = cfg.target_port[7:0];
         default:      r = b;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/udr_csr.sv @@
// Configuration registers: match and target address and port.
module udr_csr
   import udr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            CSR_MATCH_ADDR:  cfg_in.match_address  = csr_data;
            CSR_MATCH_PORT:  cfg_in.match_port     = csr_data[15:0];
            CSR_TARGET_ADDR: cfg_in.target_address = csr_data;
            CSR_TARGET_PORT: cfg_in.target_port    = csr_data[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_address  <= RST_MATCH_ADDR;
         cfg_ff.match_port     <= RST_MATCH_PORT;
         cfg_ff.target_address <= RST_TARGET_ADDR;
         cfg_ff.target_port    <= RST_TARGET_PORT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/udr_hdr_mem.sv @@
// Header byte store: one write port, one registered read port.
module udr_hdr_mem
   import udr_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [POS_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic [POS_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);

   logic [7:0] mem_ff [HOLD_LEN];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/udr_hdr_unit.sv @@
// Shared header unit: one byte compare and one ones-complement add per step.
module udr_hdr_unit
   import udr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  step_type    step,
   input  logic [7:0]  data,
   input  cfg_type     cfg,
   output logic        match_ok,
   output logic [15:0] check
);

   typedef struct packed {
      logic       hit;
      logic [7:0] value;
   } expect_type;

   // Expected value of the header bytes that select redirection
   function automatic expect_type cmp_expect(input logic [POS_W-1:0] idx,
                                             input cfg_type c);
      expect_type e;
      e.hit   = 1'b1;
      e.value = 8'd0;
      case (idx)
         IDX_ETYPE_HI: e.value = ETYPE_IPV4[15:8];
         IDX_ETYPE_LO: e.value = ETYPE_IPV4[7:0];
         IDX_PROTO:    e.value = PROTO_UDP;
         IDX_DADDR_0:  e.value = c.match_address[31:24];
         IDX_DADDR_1:  e.value = c.match_address[23:16];
         IDX_DADDR_2:  e.value = c.match_address[15:8];
         IDX_DADDR_3:  e.value = c.match_address[7:0];
         IDX_DPORT_HI: e.value = c.match_port[15:8];
         IDX_DPORT_LO: e.value = c.match_port[7:0];
         default:      e.hit   = 1'b0;
      endcase
      return e;
   endfunction

   logic        match_ff;
   logic        match_in;
   logic [15:0] acc_ff;
   logic [15:0] acc_in;
   expect_type  exp_b;
   logic        in_sum;
   logic [7:0]  sum_byte;
   logic [15:0] operand;
   logic [16:0] sum_raw;

   // Compare path
   assign exp_b = cmp_expect(step.idx, cfg);

   // Sum path: IPv4 header words with the check field left out and the target address patched in
   assign in_sum = (step.idx >= IDX_IP_FIRST) && (step.idx <= IDX_DADDR_3) &&
                   (step.idx != IDX_CHECK_HI) && (step.idx != IDX_CHECK_LO);
   assign sum_byte = hdr_patch(step.idx, data, 16'd0, cfg);
   assign operand  = step.idx[0] ? {8'd0, sum_byte} : {sum_byte, 8'd0};
   assign sum_raw  = {1'b0, acc_ff} + {1'b0, operand};

   always_comb begin
      match_in = match_ff;
      acc_in   = acc_ff;
      if (step.clear) begin
         match_in = 1'b1;
         acc_in   = 16'd0;
      end else if (step.enable) begin
         if (exp_b.hit && (data != exp_b.value)) begin
            match_in = 1'b0;
         end
         if (in_sum) begin
            // end-around carry keeps the sum folded at every step
            acc_in = sum_raw[15:0] + {15'd0, sum_raw[16]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         acc_ff   <= 16'd0;
      end else begin
         match_ff <= match_in;
         acc_ff   <= acc_in;
      end
   end

   assign match_ok = match_ff;
   assign check    = ~acc_ff;

endmodule

@@ rtl/core/udp_destination_rewrite.sv @@
// Top level: IPv4/UDP destination rewrite with header checksum rebuild.
//
//   port group   dir   handshake             contents
//   req_*        in    req_valid/req_stall   req_data: in_byte, in_last
//   rsp_*        out   rsp_valid/rsp_stall   rsp_data: out_byte, out_last, verdict
//   csr_*        in    csr_valid/csr_ready   csr_index, csr_data
//
// Bytes 1..41 of a frame are taken one per cycle and stored, and streamed bytes after
// the header pass through one per cycle, both while the output is not stalled. The 42nd
// byte starts a judge pass through the shared compare/add unit, then the header leaves
// byte by byte through a fetch state (store read), then an emit state (output register).
// A frame that ends early leaves the same way from its held bytes, unchanged.
// Reset is synchronous; csr_ready is always high. A stalled output holds the block.
module udp_destination_rewrite
   import udr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   localparam logic [POS_W-1:0] SEQ_JUDGE_END = POS_W'(IDX_DPORT_LO + 1);
   localparam logic [POS_W-1:0] SEQ_JUDGE_DONE = POS_W'(IDX_DPORT_LO + 2);
   localparam logic [POS_W-1:0] POS_STREAM = POS_W'(HOLD_LEN);

   typedef enum logic [3:0] {
      ST_RECV  = 4'b0001,
      ST_JUDGE = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] seq_ff, seq_in;
   logic [POS_W-1:0] flush_len_ff, flush_len_in;
   logic             frame_last_ff, frame_last_in;
   logic             redirect_ff, redirect_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   cfg_type          cfg;
   step_type         step;
   logic             match_ok;
   logic [15:0]      check;
   logic             mem_wr_en;
   logic [7:0]       mem_rd_data;
   logic             req_accept;
   logic             out_free;
   logic             emit_last;
   logic [7:0]       emit_byte;

   // Configuration registers
   assign csr_ready = 1'b1;

   udr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Header store
   assign mem_wr_en = req_accept && (pos_ff != POS_STREAM);

   udr_hdr_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (pos_ff),
      .wr_data (req_data.in_byte),
      .rd_addr (seq_ff),
      .rd_data (mem_rd_data)
   );

   // Judge steps: read data of the previous address is processed each cycle
   assign step.clear  = mem_wr_en && (pos_ff == IDX_LAST_HDR);
   assign step.enable = (state_ff == ST_JUDGE) && (seq_ff > IDX_ETYPE_HI) &&
                        (seq_ff <= SEQ_JUDGE_END);
   assign step.idx    = seq_ff - POS_W'(1);

   udr_hdr_unit u_unit (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .data     (mem_rd_data),
      .cfg      (cfg),
      .match_ok (match_ok),
      .check    (check)
   );

   // Handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_RECV) || !out_free;
   assign req_accept = req_valid && !req_stall;

   assign emit_last = (seq_ff == flush_len_ff - POS_W'(1));
   assign emit_byte = redirect_ff ? hdr_patch(seq_ff, mem_rd_data, check, cfg) : mem_rd_data;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      seq_in        = seq_ff;
      flush_len_in  = flush_len_ff;
      frame_last_in = frame_last_ff;
      redirect_in   = redirect_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_RECV: begin
            if (req_accept) begin
               if (pos_ff == POS_STREAM) begin
                  // pass-through after the header
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.out_byte = req_data.in_byte;
                  rsp_data_in.out_last = req_data.in_last;
                  rsp_data_in.verdict  = req_data.in_last && redirect_ff;
                  if (req_data.in_last) begin
                     pos_in      = '0;
                     redirect_in = 1'b0;
                  end
               end else if (pos_ff == IDX_LAST_HDR) begin
                  frame_last_in = req_data.in_last;
                  flush_len_in  = POS_W'(HOLD_LEN);
                  seq_in        = IDX_ETYPE_HI;
                  state_in      = ST_JUDGE;
               end else if (req_data.in_last) begin
                  // short frame leaves unchanged
                  frame_last_in = 1'b1;
                  flush_len_in  = pos_ff + POS_W'(1);
                  redirect_in   = 1'b0;
                  seq_in        = '0;
                  state_in      = ST_FETCH;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         end
         ST_JUDGE: begin
            if (seq_ff == SEQ_JUDGE_DONE) begin
               redirect_in = match_ok;
               seq_in      = '0;
               state_in    = ST_FETCH;
            end else begin
               seq_in = seq_ff + POS_W'(1);
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.out_byte = emit_byte;
               rsp_data_in.out_last = emit_last && frame_last_ff;
               rsp_data_in.verdict  = emit_last && frame_last_ff && redirect_ff;
               if (emit_last) begin
                  state_in = ST_RECV;
                  if (frame_last_ff) begin
                     pos_in      = '0;
                     redirect_in = 1'b0;
                  end else begin
                     pos_in = POS_STREAM;
                  end
               end else begin
                  seq_in   = seq_ff + POS_W'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RECV;
         pos_ff        <= '0;
         seq_ff        <= '0;
         flush_len_ff  <= '0;
         frame_last_ff <= 1'b0;
         redirect_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         seq_ff        <= seq_in;
         flush_len_ff  <= flush_len_in;
         frame_last_ff <= frame_last_in;
         redirect_ff   <= redirect_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A transmit verdict only rides on the final byte of a frame
   a_verdict_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.verdict |-> rsp_data.out_last)
      else $error("verdict set on a byte that is not the last");

   // Byte position never runs past the streaming mark
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_STREAM)
      else $error("byte position out of range");

   // Flush never reads past the held bytes
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) || (state_ff == ST_FETCH) |-> seq_ff < flush_len_ff)
      else $error("flush index beyond held bytes");

   // A short frame never leaves with a transmit verdict
   a_short_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && (flush_len_ff != POS_W'(HOLD_LEN)) |-> !redirect_ff)
      else $error("short frame marked for redirect");

endmodule
